>>> sv/md5_pkg.sv
package md5_pkg;

  // Block buffer geometry
  localparam int unsigned BlockWords = 16;
  localparam int unsigned AddrW      = $clog2(BlockWords);

  // Round registers A..D
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_work_t;

  // Chaining values at message start
  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // Padding marker byte
  localparam logic [7:0] PadMarker = 8'h80;

  // Sine-derived additive constants, one per round
  localparam logic [31:0] SineK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Message word used by a round
  function automatic logic [AddrW-1:0] msg_index(logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
      default: g = 4'(r4 * 4'd7);
    endcase
    return AddrW'(g);
  endfunction

  // Left rotate amount by quarter and position
  function automatic logic [4:0] rot_amount(logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0:    s = 5'd7;
      4'h1:    s = 5'd12;
      4'h2:    s = 5'd17;
      4'h3:    s = 5'd22;
      4'h4:    s = 5'd5;
      4'h5:    s = 5'd9;
      4'h6:    s = 5'd14;
      4'h7:    s = 5'd20;
      4'h8:    s = 5'd4;
      4'h9:    s = 5'd11;
      4'ha:    s = 5'd16;
      4'hb:    s = 5'd23;
      4'hc:    s = 5'd6;
      4'hd:    s = 5'd10;
      4'he:    s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

>>> sv/md5_block_ram.sv
module md5_block_ram (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [md5_pkg::AddrW-1:0]  wr_addr_i,
  input  logic [31:0]                wr_data_i,
  input  logic [md5_pkg::AddrW-1:0]  rd_addr_i,
  output logic [31:0]                rd_data_o
);
  import md5_pkg::*;

  logic [31:0] mem [BlockWords];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

>>> sv/md5_round.sv
module md5_round (
  input  logic [5:0]         round_i,
  input  md5_pkg::md5_work_t work_i,
  input  logic [31:0]        msg_i,
  output md5_pkg::md5_work_t work_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot_w;

  // Round function by quarter
  always_comb begin
    case (round_i[5:4])
      2'd0:    f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      2'd1:    f = (work_i.b & work_i.d) | (work_i.c & ~work_i.d);
      2'd2:    f = work_i.b ^ work_i.c ^ work_i.d;
      default: f = work_i.c ^ (work_i.b | ~work_i.d);
    endcase
  end

  assign t     = work_i.a + f + SineK[round_i] + msg_i;
  assign rot_w = {t, t} << rot_amount(round_i);

  // Shift the registers down by one
  assign work_o.a = work_i.d;
  assign work_o.b = work_i.b + rot_w[63:32];
  assign work_o.c = work_i.b;
  assign work_o.d = work_i.c;

endmodule

>>> sv/md5_message_digest.sv
// MD5 digest engine, one message byte per input word.
// Input stream: s_axis_tuser = 0 carries a message byte in s_axis_tdata;
// s_axis_tuser = 1 ends the message (tdata ignored) and starts padding.
// Output stream: four words per message, chaining words A..D in order,
// m_axis_tuser gives the word index, m_axis_tlast marks D.
// Data bytes are taken while the engine is idle; the 64th byte of a block
// starts the compression (one read prime, 64 rounds, the chaining add),
// paced by the single read port of the block
// buffer that feeds one message word per round.
// End of message: 16 - (count%64)/4 padding writes and a compression, and a
// further 16 writes and compression if under 9 bytes of block room remain;
// then the four digest words, one per cycle while the receiver takes them.
// s_axis_tready is high only while the engine is idle; a stalled receiver
// holds the current digest word and the engine waits.
// Reset loads the initial chaining values and clears the byte count; the
// block buffer needs no clearing. After the last digest word is taken the
// engine returns to the same state and the next byte starts a new message.
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast    // last
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_PRIME, ST_ROUND, ST_CHAIN, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    CK_DATA, CK_EXTRA, CK_FINAL
  } ckind_e;

  state_e           state_q;
  ckind_e           ckind_q;
  logic             second_q;
  logic [AddrW-1:0] wp_q;
  logic [5:0]       round_q;
  logic [1:0]       idx_q;
  logic [60:0]      count_q;
  logic [31:0]      chain_q [4];
  logic [31:0]      acc_q;
  md5_work_t        work_q;
  md5_work_t        work_nxt;

  logic             in_acc;
  logic             out_acc;
  logic [5:0]       pos;
  logic [63:0]      bit_len;
  logic             len_here;
  logic [31:0]      part_word;
  logic [31:0]      pad_word;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic [AddrW-1:0] rd_addr;
  logic [31:0]      rd_data;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = chain_q[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == 2'd3);

  assign pos     = count_q[5:0];
  assign bit_len = {count_q, 3'b000};

  // Last partial word: received bytes, marker, zeros
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < pos[1:0]) begin
        part_word[8*j +: 8] = acc_q[8*j +: 8];
      end else if (2'(j) == pos[1:0]) begin
        part_word[8*j +: 8] = PadMarker;
      end else begin
        part_word[8*j +: 8] = 8'h00;
      end
    end
  end

  // Padding word for the current write pointer
  assign len_here = second_q || (pos[5:3] != 3'b111);
  always_comb begin
    if (len_here && wp_q == AddrW'(14)) begin
      pad_word = bit_len[31:0];
    end else if (len_here && wp_q == AddrW'(15)) begin
      pad_word = bit_len[63:32];
    end else if (!second_q && wp_q == pos[5:2]) begin
      pad_word = part_word;
    end else begin
      pad_word = 32'h0;
    end
  end

  // Block buffer ports
  assign wr_en   = (in_acc && !s_axis_tuser && pos[1:0] == 2'd3) || (state_q == ST_PAD);
  assign wr_addr = (state_q == ST_PAD) ? wp_q : pos[5:2];
  assign wr_data = (state_q == ST_PAD) ? pad_word : {s_axis_tdata, acc_q[23:0]};
  assign rd_addr = (state_q == ST_PRIME) ? msg_index(6'd0) : msg_index(round_q + 6'd1);

  md5_block_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5_round u_round (
    .round_i (round_q),
    .work_i  (work_q),
    .msg_i   (rd_data),
    .work_o  (work_nxt)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ckind_q  <= CK_DATA;
      second_q <= 1'b0;
      wp_q     <= '0;
      round_q  <= '0;
      idx_q    <= '0;
      count_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (!s_axis_tuser) begin
              count_q <= count_q + 61'd1;
              if (pos == 6'd63) begin
                ckind_q <= CK_DATA;
                state_q <= ST_PRIME;
              end
            end else begin
              second_q <= 1'b0;
              wp_q     <= pos[5:2];
              state_q  <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (wp_q == AddrW'(BlockWords - 1)) begin
            ckind_q <= (!second_q && pos[5:3] == 3'b111) ? CK_EXTRA : CK_FINAL;
            state_q <= ST_PRIME;
          end else begin
            wp_q <= wp_q + AddrW'(1);
          end
        end
        ST_PRIME: begin
          round_q <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            state_q <= ST_CHAIN;
          end
        end
        ST_CHAIN: begin
          case (ckind_q)
            CK_EXTRA: begin
              second_q <= 1'b1;
              wp_q     <= '0;
              state_q  <= ST_PAD;
            end
            CK_FINAL: begin
              idx_q   <= '0;
              state_q <= ST_OUT;
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_OUT: begin
          if (out_acc) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              count_q <= '0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Chaining words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= InitA;
      chain_q[1] <= InitB;
      chain_q[2] <= InitC;
      chain_q[3] <= InitD;
    end else if (state_q == ST_CHAIN) begin
      chain_q[0] <= chain_q[0] + work_q.a;
      chain_q[1] <= chain_q[1] + work_q.b;
      chain_q[2] <= chain_q[2] + work_q.c;
      chain_q[3] <= chain_q[3] + work_q.d;
    end else if (out_acc && idx_q == 2'd3) begin
      chain_q[0] <= InitA;
      chain_q[1] <= InitB;
      chain_q[2] <= InitC;
      chain_q[3] <= InitD;
    end
  end

  // Byte gather and round registers
  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser) begin
      acc_q[8*pos[1:0] +: 8] <= s_axis_tdata;
    end
    if (state_q == ST_PRIME) begin
      work_q <= '{a: chain_q[0], b: chain_q[1], c: chain_q[2], d: chain_q[3]};
    end else if (state_q == ST_ROUND) begin
      work_q <= work_nxt;
    end
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while digest is pending");

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ROUND) |-> (round_q == 6'd0))
    else $error("round counter not cleared outside compression");

  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s_axis_tuser && pos == 6'd63) |=> (state_q == ST_PRIME))
    else $error("full block did not start compression");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (!m_axis_tvalid && count_q == 61'd0))
    else $error("digest end did not restart message");

endmodule
